// ===== src/rfpf_pkg.sv =====
package rfpf_pkg;

    // datapath widths
    localparam int OFS_W = 25;   // point minus robot, signed
    localparam int XW    = 36;   // CORDIC x/y, prescaled by 2^8 plus growth
    localparam int ZW    = 26;   // angle accumulator, degrees in 1/65536
    localparam int BW    = 18;   // bearing before wrap, 1/128 degree
    localparam int PRESCALE_BITS = 8;
    localparam int MAX_STAGES = 32;

    localparam logic signed [ZW-1:0] DEG90_Q16    = 26'sd5898240;
    localparam logic [23:0]          INV_GAIN_Q24 = 24'd10188014;

    localparam logic signed [BW-1:0] WRAP_TWICE_LIM = -18'sd69120;
    localparam logic signed [BW-1:0] WRAP_ONCE_LIM  = -18'sd23040;
    localparam logic signed [BW-1:0] HALF_TURN      = 18'sd23040;
    localparam logic signed [BW-1:0] FULL_TURN      = 18'sd46080;
    localparam logic signed [BW-1:0] TWO_TURNS      = 18'sd92160;

    localparam logic signed [ZW-1:0] ATAN_Q16 [MAX_STAGES] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_ROBOT_X       = 3'd0;
    localparam reg_idx_t REG_ROBOT_Y       = 3'd1;
    localparam reg_idx_t REG_ROBOT_HEADING = 3'd2;
    localparam reg_idx_t REG_MAX_RADIUS    = 3'd3;
    localparam reg_idx_t REG_MAX_TURN      = 3'd4;
    localparam reg_idx_t REG_VIEW_WIDTH    = 3'd5;

    typedef struct packed {
        logic signed [23:0] robot_x;
        logic signed [23:0] robot_y;
        logic [15:0]        robot_heading;
        logic [23:0]        max_radius;
        logic [14:0]        max_turn;
        logic [15:0]        view_width;
    } cfg_t;

    typedef struct packed {
        logic                 zero;
        logic [1:0]           kind;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_beat_t;

endpackage

// ===== src/rfpf_front.sv =====
module rfpf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic signed [23:0]    point_x,
    input  logic signed [23:0]    point_y,
    input  logic [1:0]            point_kind,
    input  rfpf_pkg::cfg_t        cfg,
    output logic                  out_vld,
    output rfpf_pkg::cordic_beat_t out_beat
);
    import rfpf_pkg::*;

    logic                    vld0_reg;
    logic signed [OFS_W-1:0] dx_reg, dx_next;
    logic signed [OFS_W-1:0] dy_reg, dy_next;
    logic [1:0]              kind_reg;

    logic                    vld1_reg;
    cordic_beat_t            beat_reg, beat_next;

    logic signed [XW-1:0]    xp, yp;

    assign dx_next = {point_x[23], point_x} - {cfg.robot_x[23], cfg.robot_x};
    assign dy_next = {point_y[23], point_y} - {cfg.robot_y[23], cfg.robot_y};

    assign xp = {{(XW-OFS_W-PRESCALE_BITS){dx_reg[OFS_W-1]}}, dx_reg, {PRESCALE_BITS{1'b0}}};
    assign yp = {{(XW-OFS_W-PRESCALE_BITS){dy_reg[OFS_W-1]}}, dy_reg, {PRESCALE_BITS{1'b0}}};

    // bring left half plane vectors into the right half before the cells
    always_comb
    begin
        beat_next.zero = (dx_reg == '0) && (dy_reg == '0);
        beat_next.kind = kind_reg;
        beat_next.x    = xp;
        beat_next.y    = yp;
        beat_next.z    = '0;
        if (xp < 0)
        begin
            if (yp >= 0)
            begin
                beat_next.x = yp;
                beat_next.y = -xp;
                beat_next.z = DEG90_Q16;
            end
            else
            begin
                beat_next.x = -yp;
                beat_next.y = xp;
                beat_next.z = -DEG90_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_vld;
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        kind_reg <= point_kind;
        beat_reg <= beat_next;
    end

    assign out_vld  = vld1_reg;
    assign out_beat = beat_reg;

endmodule

// ===== src/rfpf_cell.sv =====
module rfpf_cell #(
    parameter int SHIFT = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    input  rfpf_pkg::cordic_beat_t in_beat,
    output logic                   out_vld,
    output rfpf_pkg::cordic_beat_t out_beat
);
    import rfpf_pkg::*;

    logic                 vld_reg;
    cordic_beat_t         beat_reg, beat_next;
    logic signed [XW-1:0] xs, ys;

    assign xs = in_beat.x >>> SHIFT;
    assign ys = in_beat.y >>> SHIFT;

    // rotate toward the x axis, steering by the sign of y
    always_comb
    begin
        beat_next = in_beat;
        if (in_beat.y >= 0)
        begin
            beat_next.x = in_beat.x + ys;
            beat_next.y = in_beat.y - xs;
            beat_next.z = in_beat.z + ATAN_Q16[SHIFT];
        end
        else
        begin
            beat_next.x = in_beat.x - ys;
            beat_next.y = in_beat.y + xs;
            beat_next.z = in_beat.z - ATAN_Q16[SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_vld  = vld_reg;
    assign out_beat = beat_reg;

endmodule

// ===== src/rfpf_back.sv =====
module rfpf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    input  rfpf_pkg::cordic_beat_t in_beat,
    input  rfpf_pkg::cfg_t         cfg,
    output logic                   done,
    output logic [23:0]            range,
    output logic signed [15:0]     bearing,
    output logic [1:0]             kind_out,
    output logic                   keep
);
    import rfpf_pkg::*;

    // stage 1: gain partial products, angle scaling and heading offset
    logic                 vld1_reg;
    logic [40:0]          plo_reg, plo_next;
    logic [40:0]          phi_reg, phi_next;
    logic signed [BW-1:0] b1_reg, b1_next;
    logic [1:0]           kind1_reg;

    logic [33:0]          xc;
    logic signed [ZW-1:0] zr, zsh;
    logic signed [16:0]   b0;

    always_comb
    begin
        if (in_beat.zero || in_beat.x < 0)
            xc = '0;
        else
            xc = in_beat.x[33:0];
        if (in_beat.zero)
            zr = ZW'(256);
        else
            zr = in_beat.z + ZW'(256);
        zsh = zr >>> 9;
        b0  = zsh[16:0];
    end

    assign plo_next = {24'd0, xc[16:0]} * {17'd0, INV_GAIN_Q24};
    assign phi_next = {24'd0, xc[33:17]} * {17'd0, INV_GAIN_Q24};
    assign b1_next  = {b0[16], b0} - $signed({2'b00, cfg.robot_heading});

    // stage 2: sum and round the range, wrap the bearing
    logic                 vld2_reg;
    logic [25:0]          rng_reg;
    logic signed [15:0]   b2_reg;
    logic [1:0]           kind2_reg;
    logic [57:0]          rsum;
    logic signed [BW-1:0] bw;

    assign rsum = {phi_reg, 17'd0} + {17'd0, plo_reg} + 58'h0_0000_8000_0000;

    always_comb
    begin
        if (b1_reg <= WRAP_TWICE_LIM)
            bw = b1_reg + TWO_TURNS;
        else if (b1_reg <= WRAP_ONCE_LIM)
            bw = b1_reg + FULL_TURN;
        else if (b1_reg > HALF_TURN)
            bw = b1_reg - FULL_TURN;
        else
            bw = b1_reg;
    end

    // stage 3: window test, saturate, present the beat
    logic               done_reg;
    logic [23:0]        range_reg, range_next;
    logic signed [15:0] bearing_reg;
    logic [1:0]         kind3_reg;
    logic               keep_reg, keep_next;
    logic [15:0]        ab;
    logic [16:0]        win;

    assign ab         = (b2_reg < 0) ? 16'(-b2_reg) : 16'(b2_reg);
    assign win        = {1'b0, cfg.max_turn, 1'b0} + {1'b0, cfg.view_width};
    assign range_next = (|rng_reg[25:24]) ? 24'hFF_FFFF : rng_reg[23:0];
    assign keep_next  = (rng_reg <= {2'b00, cfg.max_radius}) && ({ab, 1'b0} <= win);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            done_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        b1_reg      <= b1_next;
        kind1_reg   <= in_beat.kind;
        rng_reg     <= rsum[57:32];
        b2_reg      <= bw[15:0];
        kind2_reg   <= kind1_reg;
        range_reg   <= range_next;
        bearing_reg <= b2_reg;
        kind3_reg   <= kind2_reg;
        keep_reg    <= keep_next;
    end

    assign done     = done_reg;
    assign range    = range_reg;
    assign bearing  = bearing_reg;
    assign kind_out = kind3_reg;
    assign keep     = keep_reg;

endmodule

// ===== src/robot_frame_polar_point_filter.sv =====
// Channel  | Direction | Handshake         | Beat
// ---------+-----------+-------------------+----------------------------------------
// point    | in        | start & !busy     | point_x, point_y, point_kind
// result   | out       | done (one cycle)  | range, bearing, kind_out, keep
// config   | in        | cfg_we            | cfg_index, cfg_data
//
// One point enters every cycle; busy never rises.
// From accept to done a point passes two front stages, one cell per CORDIC
// iteration, and three stages for gain, wrap and window.
// rst_n clears the valid chain and loads the register reset values.
// The receiver cannot stall: each result shows on done for exactly one cycle.
module robot_frame_polar_point_filter #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic [1:0]         point_kind,
    output logic               done,
    output logic [23:0]        range,
    output logic signed [15:0] bearing,
    output logic [1:0]         kind_out,
    output logic               keep,
    input  logic               cfg_we,
    input  rfpf_pkg::reg_idx_t cfg_index,
    input  logic [23:0]        cfg_data
);
    import rfpf_pkg::*;

    localparam int NCELL   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int LATENCY = NCELL + 5;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.robot_x       <= '0;
            cfg_reg.robot_y       <= '0;
            cfg_reg.robot_heading <= '0;
            cfg_reg.max_radius    <= 24'hFF_FFFF;
            cfg_reg.max_turn      <= 15'd11520;
            cfg_reg.view_width    <= 16'd7680;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROBOT_X:       cfg_reg.robot_x       <= cfg_data;
                REG_ROBOT_Y:       cfg_reg.robot_y       <= cfg_data;
                REG_ROBOT_HEADING: cfg_reg.robot_heading <= cfg_data[15:0];
                REG_MAX_RADIUS:    cfg_reg.max_radius    <= cfg_data;
                REG_MAX_TURN:      cfg_reg.max_turn      <= cfg_data[14:0];
                REG_VIEW_WIDTH:    cfg_reg.view_width    <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic         accept;
    logic         chain_vld  [NCELL+1];
    cordic_beat_t chain_beat [NCELL+1];

    assign accept = start && !busy;

    rfpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (accept),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_kind (point_kind),
        .cfg        (cfg_reg),
        .out_vld    (chain_vld[0]),
        .out_beat   (chain_beat[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        rfpf_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (chain_vld[i]),
            .in_beat  (chain_beat[i]),
            .out_vld  (chain_vld[i+1]),
            .out_beat (chain_beat[i+1])
        );
    end

    rfpf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (chain_vld[NCELL]),
        .in_beat  (chain_beat[NCELL]),
        .cfg      (cfg_reg),
        .done     (done),
        .range    (range),
        .bearing  (bearing),
        .kind_out (kind_out),
        .keep     (keep)
    );

    logic [15:0] bearing_abs;
    logic [16:0] window;

    assign bearing_abs = (bearing < 0) ? 16'(-bearing) : 16'(bearing);
    assign window      = {1'b0, cfg_reg.max_turn, 1'b0} + {1'b0, cfg_reg.view_width};

    a_done_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY)
    ) else $error("result beat without matching accepted point");

    a_accept_gives_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(start && !busy, LATENCY) && $past(rst_n, LATENCY) |-> done
    ) else $error("accepted point produced no result beat");

    a_bearing_wrapped: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (bearing > -16'sd23040) && (bearing <= 16'sd23040)
    ) else $error("bearing outside (-180,180] degrees");

    a_keep_in_window: assert property (
        @(posedge clk) disable iff (!rst_n)
        done && keep |-> ({bearing_abs, 1'b0} <= window) && (range <= cfg_reg.max_radius)
    ) else $error("keep set outside range or head window");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int  CORDIC_STAGES = 16;
    localparam int  ITERATIONS    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int  LATENCY       = ITERATIONS + 5;
    localparam int  CYCLE_LIMIT   = 500000;
    localparam int  PRINT_LIMIT   = 40;

    localparam longint DEG_360_Q7   = 46080;
    localparam longint DEG_180_Q7   = 23040;
    localparam longint DEG_90_Q16   = 5898240;
    localparam longint unsigned GAIN_RECIP_Q24 = 10188014;

    localparam logic [23:0] POS_MIN = 24'h800000;
    localparam logic [23:0] POS_MAX = 24'h7FFFFF;

    // arctan(2^-i) in degrees, 1/65536 units
    localparam longint ATAN_DEG_Q16 [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [1:0]         kind;
    } map_point_t;

    typedef struct packed {
        logic [23:0]        rng;
        logic signed [15:0] bearing;
        logic [1:0]         kind;
        logic               keep;
    } polar_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [23:0] point_x = '0;
    logic signed [23:0] point_y = '0;
    logic [1:0]         point_kind = '0;
    logic               done;
    logic [23:0]        range;
    logic signed [15:0] bearing;
    logic [1:0]         kind_out;
    logic               keep;
    logic               cfg_we = 1'b0;
    rfpf_pkg::reg_idx_t cfg_index = rfpf_pkg::REG_ROBOT_X;
    logic [23:0]        cfg_data = '0;

    map_point_t points_to_send[$];
    polar_t     polar_expected[$];

    // register copies as the block should hold them
    longint          robot_x_now = 0;
    longint          robot_y_now = 0;
    longint          heading_now = 0;
    longint          max_radius_now = 16777215;
    longint          max_turn_now = 11520;
    longint          view_width_now = 7680;

    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              gap_left = 0;
    int              burst_left = 0;

    robot_frame_polar_point_filter #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_kind(point_kind),
        .done      (done),
        .range     (range),
        .bearing   (bearing),
        .kind_out  (kind_out),
        .keep      (keep),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic polar_t predict_polar(map_point_t p);
        longint          dx;
        longint          dy;
        longint          vx;
        longint          vy;
        longint          t;
        longint          xs;
        longint          ys;
        longint          ang;
        longint          b;
        longint          ab;
        longint unsigned dist_full;
        int              i;
        polar_t          r;
        dx = longint'(p.x) - robot_x_now;
        dy = longint'(p.y) - robot_y_now;
        ang = 0;
        dist_full = 0;
        if (dx != 0 || dy != 0)
        begin
            vx = dx * 256;
            vy = dy * 256;
            // fold the left half plane into the right one
            if (vx < 0)
            begin
                t = vx;
                if (vy >= 0)
                begin
                    vx = vy;
                    vy = -t;
                    ang = DEG_90_Q16;
                end
                else
                begin
                    vx = -vy;
                    vy = t;
                    ang = -DEG_90_Q16;
                end
            end
            for (i = 0; i < ITERATIONS; i++)
            begin
                xs = vx >>> i;
                ys = vy >>> i;
                if (vy >= 0)
                begin
                    vx = vx + ys;
                    vy = vy - xs;
                    ang = ang + ATAN_DEG_Q16[i];
                end
                else
                begin
                    vx = vx - ys;
                    vy = vy + xs;
                    ang = ang - ATAN_DEG_Q16[i];
                end
            end
            if (vx < 0)
                vx = 0;
            dist_full = (unsigned'(vx) * GAIN_RECIP_Q24 + 64'h8000_0000) >> 32;
        end
        b = (ang + 256) >>> 9;
        b = b - heading_now;
        b = b % DEG_360_Q7;
        if (b < 0)
            b = b + DEG_360_Q7;
        if (b > DEG_180_Q7)
            b = b - DEG_360_Q7;
        ab = (b < 0) ? -b : b;
        r.rng     = (dist_full > 64'hFF_FFFF) ? 24'hFF_FFFF : dist_full[23:0];
        r.bearing = b[15:0];
        r.kind    = p.kind;
        // the window test uses the range before saturation
        r.keep    = (dist_full <= unsigned'(max_radius_now)) &&
                    (2 * ab <= 2 * max_turn_now + view_width_now);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(rfpf_pkg::reg_idx_t idx, logic [23:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            rfpf_pkg::REG_ROBOT_X:       robot_x_now    = longint'(signed'(val));
            rfpf_pkg::REG_ROBOT_Y:       robot_y_now    = longint'(signed'(val));
            rfpf_pkg::REG_ROBOT_HEADING: heading_now    = val[15:0];
            rfpf_pkg::REG_MAX_RADIUS:    max_radius_now = val;
            rfpf_pkg::REG_MAX_TURN:      max_turn_now   = val[14:0];
            rfpf_pkg::REG_VIEW_WIDTH:    view_width_now = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (points_to_send.size() != 0 || start || polar_expected.size() != 0);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic add_point(logic [23:0] x, logic [23:0] y, logic [1:0] kind);
        map_point_t p;
        p.x = x;
        p.y = y;
        p.kind = kind;
        points_to_send.push_back(p);
    endtask

    function automatic logic [23:0] near_robot(longint center);
        longint off;
        off = $urandom_range(0, 1 << $urandom_range(0, 16));
        if ($urandom_range(0, 1))
            off = -off;
        return 24'(center + off);
    endfunction

    function automatic logic [23:0] corner_coord(longint center);
        case ($urandom_range(0, 3))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return 24'd0;
            default: return 24'(center);
        endcase
    endfunction

    task automatic add_random_point();
        int          mode;
        logic [23:0] x;
        logic [23:0] y;
        logic [1:0]  kind;
        mode = $urandom_range(0, 9);
        if (mode < 4)
        begin
            x = 24'($urandom);
            y = 24'($urandom);
        end
        else if (mode < 8)
        begin
            x = near_robot(robot_x_now);
            y = near_robot(robot_y_now);
        end
        else if (mode == 8)
        begin
            x = corner_coord(robot_x_now);
            y = corner_coord(robot_y_now);
        end
        else
        begin
            // on an axis through the robot, or on the robot itself
            x = 24'(robot_x_now);
            y = 24'(robot_y_now);
            case ($urandom_range(0, 2))
                0: x = near_robot(robot_x_now);
                1: y = near_robot(robot_y_now);
                default: ;
            endcase
        end
        kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        add_point(x, y, kind);
    endtask

    function automatic logic [23:0] pick_reg_value(rfpf_pkg::reg_idx_t idx);
        int r;
        r = $urandom_range(0, 5);
        case (idx)
            rfpf_pkg::REG_ROBOT_X, rfpf_pkg::REG_ROBOT_Y:
                case (r)
                    0: return POS_MIN;
                    1: return POS_MAX;
                    2: return 24'd0;
                    default: return 24'($urandom);
                endcase
            rfpf_pkg::REG_ROBOT_HEADING:
                case (r)
                    0: return 24'd0;
                    1: return 24'd46079;
                    2: return 24'($urandom);
                    default: return 24'($urandom_range(0, 46079));
                endcase
            rfpf_pkg::REG_MAX_RADIUS:
                case (r)
                    0: return 24'd0;
                    1: return 24'hFF_FFFF;
                    2: return 24'($urandom_range(0, 4095));
                    default: return 24'($urandom);
                endcase
            rfpf_pkg::REG_MAX_TURN:
                case (r)
                    0: return 24'd0;
                    1: return 24'hFF_FFFF;
                    2: return 24'd23040;
                    default: return 24'($urandom_range(0, 23040));
                endcase
            default:
                case (r)
                    0: return 24'd0;
                    1: return 24'hFF_FFFF;
                    2: return 24'd46080;
                    default: return 24'($urandom_range(0, 46080));
                endcase
        endcase
    endfunction

    // point driver
    always @(posedge clk)
    begin : drive
        map_point_t p;
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && busy))
        begin
            if (start)
            begin
                p.x = point_x;
                p.y = point_y;
                p.kind = point_kind;
                polar_expected.push_back(predict_polar(p));
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (points_to_send.size() != 0)
            begin
                p = points_to_send.pop_front();
                point_x    <= p.x;
                point_y    <= p.y;
                point_kind <= p.kind;
                start      <= 1'b1;
                gap_left   = pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch
        polar_t e;
        if (rst_n && done)
        begin
            if (polar_expected.size() == 0)
                report_mismatch("unexpected beat, range", range, -1);
            else
            begin
                e = polar_expected.pop_front();
                if (range !== e.rng)
                    report_mismatch("range", range, e.rng);
                if (bearing !== e.bearing)
                    report_mismatch("bearing", bearing, e.bearing);
                if (kind_out !== e.kind)
                    report_mismatch("kind_out", kind_out, e.kind);
                if (keep !== e.keep)
                    report_mismatch("keep", keep, e.keep);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: axes, both half planes, the robot itself, corners
        add_point(24'd0, 24'd0, 2'd0);
        add_point(24'd256, 24'd0, 2'd1);
        add_point(24'd0, 24'd256, 2'd2);
        add_point(-24'sd256, 24'd0, 2'd3);
        add_point(24'd0, -24'sd256, 2'd0);
        add_point(-24'sd300, 24'd500, 2'd1);
        add_point(-24'sd300, -24'sd500, 2'd2);
        add_point(POS_MAX, POS_MAX, 2'd0);
        add_point(POS_MIN, POS_MIN, 2'd1);
        add_point(POS_MIN, POS_MAX, 2'd2);
        add_point(POS_MAX, POS_MIN, 2'd0);
        add_point(24'd1, 24'd1, 2'd1);
        add_point(-24'sd1, -24'sd1, 2'd2);
        wait_idle();

        // robot in one corner: range saturation, heading past a full turn, odd view
        write_reg(rfpf_pkg::REG_ROBOT_X, POS_MAX);
        write_reg(rfpf_pkg::REG_ROBOT_Y, POS_MAX);
        write_reg(rfpf_pkg::REG_ROBOT_HEADING, 24'd65535);
        write_reg(rfpf_pkg::REG_MAX_RADIUS, 24'd1000);
        write_reg(rfpf_pkg::REG_MAX_TURN, 24'd0);
        write_reg(rfpf_pkg::REG_VIEW_WIDTH, 24'd1);
        add_point(POS_MIN, POS_MIN, 2'd0);
        add_point(POS_MAX, POS_MAX, 2'd1);
        add_point(POS_MAX - 24'd500, POS_MAX, 2'd2);
        add_point(POS_MAX, POS_MAX - 24'd700, 2'd0);
        add_point(POS_MIN, POS_MAX, 2'd1);
        add_point(POS_MAX - 24'd3, POS_MAX - 24'd3, 2'd3);
        add_point(POS_MAX, POS_MIN, 2'd2);
        wait_idle();

        // robot in the opposite corner, window wide open, zero radius
        write_reg(rfpf_pkg::REG_ROBOT_X, POS_MIN);
        write_reg(rfpf_pkg::REG_ROBOT_Y, POS_MIN);
        write_reg(rfpf_pkg::REG_ROBOT_HEADING, 24'd46079);
        write_reg(rfpf_pkg::REG_MAX_RADIUS, 24'd0);
        write_reg(rfpf_pkg::REG_MAX_TURN, 24'h7FFF);
        write_reg(rfpf_pkg::REG_VIEW_WIDTH, 24'hFFFF);
        add_point(POS_MAX, POS_MAX, 2'd0);
        add_point(POS_MIN, POS_MIN, 2'd1);
        add_point(POS_MIN + 24'd10, POS_MIN, 2'd2);
        wait_idle();

        for (phase = 0; phase < 8; phase++)
        begin
            for (k = 0; k < 6; k++)
            begin
                if (phase == 0 || $urandom_range(0, 4) != 0)
                    write_reg(rfpf_pkg::reg_idx_t'(k),
                              pick_reg_value(rfpf_pkg::reg_idx_t'(k)));
            end
            @(negedge clk);
            n = $urandom_range(150, 250);
            repeat (n) add_random_point();
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
